### rtl/lip_pkg.sv
`default_nettype none
package lip_pkg;

  localparam int MAX_ROW_PIXELS = 4096;
  localparam int COL_W          = $clog2(MAX_ROW_PIXELS);
  localparam int PIX_W          = 8;
  localparam int RES_W          = 10;
  localparam int MODE_W         = 3;
  localparam int WIDTH_W        = 13;
  localparam int HEIGHT_W       = 14;
  localparam int CFG_DATA_W     = 14;
  localparam int CFG_INDEX_W    = 2;

  typedef enum logic [MODE_W-1:0] {
    PM_LEFT     = 3'd0,
    PM_UP       = 3'd1,
    PM_UP_LEFT  = 3'd2,
    PM_PLANE    = 3'd3,
    PM_LEFT_HALF = 3'd4,
    PM_UP_HALF  = 3'd5,
    PM_AVERAGE  = 3'd6,
    PM_MED      = 3'd7
  } pred_mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_reg_t;

  // per-pixel context handed from the counter stage to the residual stage
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [PIX_W-1:0] left;
    logic             col_ok;
    logic             row_ok;
    logic             row_end;
    logic             frame_end;
  } item_t;

  function automatic logic signed [10:0] predict(
    pred_mode_t       mode,
    logic [PIX_W-1:0] a,
    logic [PIX_W-1:0] b,
    logic [PIX_W-1:0] c
  );
    logic signed [10:0] sa, sb, sc;
    logic signed [10:0] plane, dbc, dac, tbc, tac, mx, mn, p;
    sa    = $signed({3'b000, a});
    sb    = $signed({3'b000, b});
    sc    = $signed({3'b000, c});
    plane = sa + sb - sc;
    dbc   = sb - sc;
    dac   = sa - sc;
    // halve toward zero: bias negatives by one before the arithmetic shift
    tbc   = dbc + ((dbc < 0) ? 11'sd1 : 11'sd0);
    tac   = dac + ((dac < 0) ? 11'sd1 : 11'sd0);
    mx    = (sa > sb) ? sa : sb;
    mn    = (sa > sb) ? sb : sa;
    unique case (mode)
      PM_LEFT:      p = sa;
      PM_UP:        p = sb;
      PM_UP_LEFT:   p = sc;
      PM_PLANE:     p = plane;
      PM_LEFT_HALF: p = sa + (tbc >>> 1);
      PM_UP_HALF:   p = sb + (tac >>> 1);
      PM_AVERAGE:   p = (sa + sb) >>> 1;
      PM_MED: begin
        if (sc >= mx) p = mn;
        else if (sc <= mn) p = mx;
        else p = plane;
      end
      default:      p = plane;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

### rtl/lip_ifs.sv
`default_nettype none
interface lip_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [lip_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface lip_residual_if;
  logic                             valid;
  logic                             ready;
  logic signed [lip_pkg::RES_W-1:0] residual;
  logic                             row_end;
  logic                             frame_end;

  modport source (output valid, output residual, output row_end, output frame_end, input ready);
  modport sink   (input valid, input residual, input row_end, input frame_end, output ready);
endinterface
`default_nettype wire

### rtl/lip_line_mem.sv
`default_nettype none
// Single-port synchronous RAM, read-first: a read and a write of the same
// address in one cycle return the old contents.
module lip_line_mem #(
  parameter int DEPTH  = 4096,
  parameter int DATA_W = 8
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [DATA_W-1:0]        wdata,
  output logic      [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      rdata     <= mem[addr];
      mem[addr] <= wdata;
    end
  end

endmodule
`default_nettype wire

### rtl/lip_residual_stage.sv
`default_nettype none
// Takes the pixel context plus the line buffer read data, forms the
// prediction and residual, and holds the result in the output register.
module lip_residual_stage (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         item_valid,
  input  wire lip_pkg::item_t               item,
  output logic                              item_ready,
  input  wire logic [lip_pkg::PIX_W-1:0]    up_data,
  input  wire lip_pkg::pred_mode_t          mode,
  lip_residual_if.source                    residuals
);

  logic                             s1_valid;
  lip_pkg::item_t                   s1;
  logic [lip_pkg::PIX_W-1:0]        upper_left;
  logic                             s1_advance;
  logic [lip_pkg::PIX_W-1:0]        a, b, c;
  logic signed [10:0]               pred;
  logic signed [10:0]               diff;
  logic                             res_valid;
  logic signed [lip_pkg::RES_W-1:0] res_value;
  logic                             res_row_end;
  logic                             res_frame_end;

  assign s1_advance = s1_valid && (!res_valid || residuals.ready);
  assign item_ready = !s1_valid || s1_advance;

  // neighbors outside the frame read as zero
  assign a    = s1.col_ok ? s1.left : '0;
  assign b    = s1.row_ok ? up_data : '0;
  assign c    = (s1.col_ok && s1.row_ok) ? upper_left : '0;
  assign pred = lip_pkg::predict(mode, a, b, c);
  assign diff = $signed({3'b000, s1.pixel}) - pred;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1 <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_left <= '0;
    end else if (s1_advance) begin
      upper_left <= s1.row_end ? '0 : b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_advance) begin
      res_valid <= 1'b1;
    end else if (residuals.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      res_value     <= diff[lip_pkg::RES_W-1:0];
      res_row_end   <= s1.row_end;
      res_frame_end <= s1.frame_end;
    end
  end

  assign residuals.valid     = res_valid;
  assign residuals.residual  = res_value;
  assign residuals.row_end   = res_row_end;
  assign residuals.frame_end = res_frame_end;

endmodule
`default_nettype wire

### rtl/lossless_image_predictor.sv
// Lossless image predictor.
// pixels: 8-bit grey samples in raster order, one transfer per pixel.
// residuals: one transfer per pixel with the signed 10-bit residual
//   (pixel minus prediction) and row_end / frame_end flags.
// Configuration: cfg_write/cfg_index/cfg_data; index 0 predictor mode
//   (0..6 lossless JPEG predictors 1..7, 7 median edge detector), 1 frame
//   width, 2 frame height. Write only while no pixel is in flight.
// Throughput: one pixel per clock while the receiver accepts results. The
//   line buffer is a single-port read-first RAM; each pixel reads and
//   overwrites its column in the same cycle, so no forwarding is needed.
// Pipeline: each pixel passes the RAM read stage, then the output register.
// When the receiver stalls, the output register holds its result and the
//   stage behind it holds one more pixel; then pixels.ready drops.
// Reset: counters, neighbor registers and pipeline valids clear; mode
//   resets to the median edge detector, width and height to 1. The line
//   buffer is not cleared; row 0 never uses it.
`default_nettype none
module lossless_image_predictor (
  input  wire logic                               clk,
  input  wire logic                               rst,
  lip_pixel_if.sink                               pixels,
  lip_residual_if.source                          residuals,
  input  wire logic                               cfg_write,
  input  wire logic [lip_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [lip_pkg::CFG_DATA_W-1:0]     cfg_data
);

  lip_pkg::pred_mode_t            mode;
  logic [lip_pkg::WIDTH_W-1:0]    frame_width;
  logic [lip_pkg::HEIGHT_W-1:0]   frame_height;
  logic [lip_pkg::WIDTH_W-1:0]    eff_width;
  logic [lip_pkg::HEIGHT_W-1:0]   eff_height;
  logic [lip_pkg::COL_W-1:0]      column_index;
  logic [lip_pkg::HEIGHT_W-1:0]   row_index;
  logic [lip_pkg::PIX_W-1:0]      left_value;
  logic [lip_pkg::WIDTH_W:0]      col_plus;
  logic [lip_pkg::HEIGHT_W:0]     row_plus;
  logic                           in_fire;
  logic                           item_ready;
  lip_pkg::item_t                 item;
  logic [lip_pkg::PIX_W-1:0]      up_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= lip_pkg::PM_MED;
      frame_width  <= lip_pkg::WIDTH_W'(1);
      frame_height <= lip_pkg::HEIGHT_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        lip_pkg::CFG_MODE:   mode <= lip_pkg::pred_mode_t'(cfg_data[lip_pkg::MODE_W-1:0]);
        lip_pkg::CFG_WIDTH:  frame_width <= cfg_data[lip_pkg::WIDTH_W-1:0];
        lip_pkg::CFG_HEIGHT: frame_height <= cfg_data[lip_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one; width clamps to the line buffer depth
  always_comb begin
    if (frame_width == '0) eff_width = lip_pkg::WIDTH_W'(1);
    else if (frame_width > lip_pkg::WIDTH_W'(lip_pkg::MAX_ROW_PIXELS))
      eff_width = lip_pkg::WIDTH_W'(lip_pkg::MAX_ROW_PIXELS);
    else eff_width = frame_width;
    eff_height = (frame_height == '0) ? lip_pkg::HEIGHT_W'(1) : frame_height;
  end

  assign in_fire      = pixels.valid && pixels.ready;
  assign pixels.ready = item_ready;

  assign col_plus = (lip_pkg::WIDTH_W+1)'(column_index) + 1'b1;
  assign row_plus = {1'b0, row_index} + 1'b1;

  always_comb begin
    item.pixel     = pixels.pixel;
    item.left      = left_value;
    item.col_ok    = column_index != '0;
    item.row_ok    = row_index != '0;
    item.row_end   = col_plus >= {1'b0, eff_width};
    item.frame_end = item.row_end && (row_plus >= {1'b0, eff_height});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      row_index    <= '0;
      left_value   <= '0;
    end else if (in_fire) begin
      if (item.row_end) begin
        column_index <= '0;
        left_value   <= '0;
        row_index    <= item.frame_end ? '0 : row_plus[lip_pkg::HEIGHT_W-1:0];
      end else begin
        column_index <= col_plus[lip_pkg::COL_W-1:0];
        left_value   <= pixels.pixel;
      end
    end
  end

  lip_line_mem #(
    .DEPTH  (lip_pkg::MAX_ROW_PIXELS),
    .DATA_W (lip_pkg::PIX_W)
  ) u_line_mem (
    .clk   (clk),
    .en    (in_fire),
    .addr  (column_index),
    .wdata (pixels.pixel),
    .rdata (up_data)
  );

  lip_residual_stage u_residual_stage (
    .clk        (clk),
    .rst        (rst),
    .item_valid (pixels.valid),
    .item       (item),
    .item_ready (item_ready),
    .up_data    (up_data),
    .mode       (mode),
    .residuals  (residuals)
  );

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    in_fire && item.frame_end |=> column_index == '0 && row_index == '0)
    else $error("counters not cleared after frame end");

  a_frame_in_row: assert property (@(posedge clk) disable iff (rst)
    residuals.valid && residuals.frame_end |-> residuals.row_end)
    else $error("frame end without row end");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    (lip_pkg::WIDTH_W+1)'(column_index) < {1'b0, eff_width} || !in_fire || item.row_end)
    else $error("column index past row end without row end flag");

  a_left_cleared: assert property (@(posedge clk) disable iff (rst)
    in_fire && item.row_end |=> left_value == '0)
    else $error("left neighbor not cleared at row end");

endmodule
`default_nettype wire
